>>> rtl/conv3x3_rgb_zero_pad_core_defines.svh
// ----------------------------------------------------------------------------
// conv3x3 rgb zero-pad core: assertion macros
// concurrent check macros shared by the rtl; empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CONV3X3_RGB_ZERO_PAD_CORE_DEFINES_SVH
`define CONV3X3_RGB_ZERO_PAD_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CV3_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("cv3 check failed");

// next-cycle implication
`define CV3_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("cv3 check failed");

`else

`define CV3_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define CV3_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

>>> rtl/cv3_pkg.sv
// ----------------------------------------------------------------------------
// cv3_pkg
// shared constants, register codes and types of the 3x3 rgb convolution core
// ----------------------------------------------------------------------------
package cv3_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_COEF_BITS = 8;

    localparam int MAX_HEIGHT = 4096;

    // pixel and kernel geometry
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = NUM_CH * CH_W;
    localparam int KERNEL_DIM = 3;
    localparam int NUM_TAPS   = KERNEL_DIM * KERNEL_DIM;
    localparam int SUM_W      = 20;

    // stream payload widths
    localparam int IN_DATA_W  = PIX_W;
    localparam int OUT_DATA_W = ((NUM_CH * SUM_W + 7) / 8) * 8;

    // counters and configuration registers
    localparam int ROW_W        = 13;
    localparam int IMG_WIDTH_W  = 11;
    localparam int IMG_HEIGHT_W = 13;
    localparam int COEF_ROW_W   = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd4;

    localparam logic [IMG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [IMG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd1024;
    localparam logic [COEF_ROW_W-1:0]   RST_COEF_TOP     = 24'hFFFFFF;
    localparam logic [COEF_ROW_W-1:0]   RST_COEF_MIDDLE  = 24'hFF08FF;
    localparam logic [COEF_ROW_W-1:0]   RST_COEF_BOTTOM  = 24'hFFFFFF;

    // item kind carried in tuser
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // per-item control travelling beside the data pipeline
    typedef struct packed {
        logic emit;
        logic last;
        logic top_skip;
        logic bot_skip;
        logic left_skip;
        logic right_skip;
    } cv3_ctl_t;

endpackage

>>> rtl/cv3_linebuf.sv
// ----------------------------------------------------------------------------
// cv3_linebuf
// two line stores in one memory, read-after-write forwarding and 3x3 window
// ----------------------------------------------------------------------------
module cv3_linebuf
    import cv3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  pix_t                         pix_in,
    input  logic                         wr_step,
    output logic                         clearing,
    output pix_t [NUM_TAPS-1:0]          window
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WORD_W = 2 * PIX_W;

    // word layout: upper line in the high half, lower line in the low half
    logic [WORD_W-1:0] line_mem [MAX_WIDTH];

    logic [WORD_W-1:0] rd_data_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic              fwd_reg;
    logic [ADDR_W-1:0] addr_reg;
    pix_t              pix_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clearing_reg;
    pix_t [NUM_TAPS-1:0] win_reg;
    pix_t [NUM_TAPS-1:0] win_next;

    logic [WORD_W-1:0] word_eff;
    pix_t              upper_eff;
    pix_t              lower_eff;
    logic [WORD_W-1:0] wr_word;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              fwd_next;

    assign word_eff  = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign upper_eff = word_eff[WORD_W-1:PIX_W];
    assign lower_eff = word_eff[PIX_W-1:0];
    assign wr_word   = {lower_eff, pix_reg};

    assign mem_we    = clearing_reg | wr_step;
    assign mem_waddr = clearing_reg ? clr_cnt_reg : addr_reg;
    assign mem_wdata = clearing_reg ? '0 : wr_word;

    // same column written by the item ahead while this one reads
    assign fwd_next = wr_step && (addr_reg == rd_addr);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            addr_reg     <= rd_addr;
            pix_reg      <= pix_in;
            fwd_data_reg <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= fwd_next;
        end
    end

    // clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == ADDR_W'(MAX_WIDTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        win_next = win_reg;
        for (int k = 0; k < KERNEL_DIM; k++)
        begin
            win_next[k*KERNEL_DIM]     = win_reg[k*KERNEL_DIM + 1];
            win_next[k*KERNEL_DIM + 1] = win_reg[k*KERNEL_DIM + 2];
        end
        win_next[KERNEL_DIM - 1]       = upper_eff;
        win_next[2*KERNEL_DIM - 1]     = lower_eff;
        win_next[NUM_TAPS - 1]         = pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (wr_step)
        begin
            win_reg <= win_next;
        end
    end

    assign window   = win_reg;
    assign clearing = clearing_reg;

endmodule

>>> rtl/cv3_lane.sv
// ----------------------------------------------------------------------------
// cv3_lane
// one colour channel: nine tap products, registered, then a registered sum
// ----------------------------------------------------------------------------
module cv3_lane
    import cv3_pkg::*;
#(
    parameter int COEF_BITS = DEF_COEF_BITS
)
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [NUM_TAPS-1:0][CH_W-1:0]        taps,
    input  logic [NUM_TAPS-1:0][COEF_BITS-1:0]   coefs,
    input  logic [NUM_TAPS-1:0]                  tap_en,
    output logic signed [SUM_W-1:0]              sum
);

    localparam int PROD_W = CH_W + 1 + COEF_BITS;
    localparam int ACC_W  = (PROD_W + 4 > SUM_W) ? PROD_W + 4 : SUM_W;

    logic signed [PROD_W-1:0] prod_next [NUM_TAPS];
    logic signed [PROD_W-1:0] prod_reg  [NUM_TAPS];
    logic signed [ACC_W-1:0]  row_sum   [KERNEL_DIM];
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;

    // pixel is unsigned, coefficient signed
    always_comb
    begin
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            if (tap_en[i])
            begin
                prod_next[i] = $signed({1'b0, taps[i]}) * $signed(coefs[i]);
            end
            else
            begin
                prod_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < KERNEL_DIM; k++)
        begin
            row_sum[k] = ACC_W'(prod_reg[k*KERNEL_DIM])
                       + ACC_W'(prod_reg[k*KERNEL_DIM + 1])
                       + ACC_W'(prod_reg[k*KERNEL_DIM + 2]);
        end
        acc_next = row_sum[0] + row_sum[1] + row_sum[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign sum = acc_reg[SUM_W-1:0];

endmodule

>>> rtl/cv3_merge.sv
// ----------------------------------------------------------------------------
// cv3_merge
// packs the three channel sums and the frame flag into the output register
// ----------------------------------------------------------------------------
module cv3_merge
    import cv3_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [NUM_CH-1:0][SUM_W-1:0]    sums,
    input  logic                            last,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [OUT_DATA_W-1:0]           out_data,
    output logic                            out_last
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [OUT_DATA_W-1:0] data_reg;
    logic                  last_reg;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // blue in the low bits, zero fill on top
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= OUT_DATA_W'(sums);
            last_reg <= last;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

>>> rtl/conv3x3_rgb_zero_pad_core.sv
// ----------------------------------------------------------------------------
// conv3x3_rgb_zero_pad_core
// streaming 3x3 convolution of a b,g,r pixel stream with zero padding
// ----------------------------------------------------------------------------
// usage
// - s_axis: one pixel per transaction in raster order, tuser marks a flush
//   item (taken as a black pixel); after each frame send width+1 flush items
// - m_axis: one signed sum per channel per output pixel, tlast on the
//   bottom-right pixel of the frame; output frame has the input's size
// - cfg: one register write per transaction (index, data), always ready;
//   write only while no item is in flight
// - throughput: one pixel per clock while the receiver takes results
// - path: a result leaves after the transaction of the item one row and one
//   pixel behind its centre, through the line store read, window, products,
//   sum and output registers
// - reset: the line stores are swept to zero, one column per cycle, over all
//   MAX_WIDTH columns; s_axis_tready stays low meanwhile, cfg is taken
// - stall: a waiting result does not block intake until the next result
//   reaches the sum stage; then the whole pipeline holds
// ----------------------------------------------------------------------------
`include "conv3x3_rgb_zero_pad_core_defines.svh"

module conv3x3_rgb_zero_pad_core
    import cv3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int COEF_BITS = DEF_COEF_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,   // blue_in, green_in, red_in
    input  logic                    s_axis_tuser,   // kind
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,   // blue_sum, green_sum, red_sum, zero fill
    output logic                    m_axis_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (WID_W > IMG_WIDTH_W) ? WID_W : IMG_WIDTH_W;
    localparam int CROW_W = KERNEL_DIM * COEF_BITS;

    // configuration registers
    logic [IMG_WIDTH_W-1:0]  image_width_reg;
    logic [IMG_HEIGHT_W-1:0] image_height_reg;
    logic [COEF_ROW_W-1:0]   coef_top_reg;
    logic [COEF_ROW_W-1:0]   coef_middle_reg;
    logic [COEF_ROW_W-1:0]   coef_bottom_reg;

    // position of the arriving item
    logic [CNT_W-1:0] column_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [CNT_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;

    // clamped frame size
    logic [CMP_W-1:0]        w_raw;
    logic [CMP_W-1:0]        w_cl;
    logic [WID_W-1:0]        w;
    logic [WID_W-1:0]        w_m1;
    logic [IMG_HEIGHT_W-1:0] h;
    logic [IMG_HEIGHT_W-1:0] h_m1;

    // position decode of the arriving item
    logic [CNT_W-1:0] col_c;
    logic [ROW_W-1:0] row_c;
    logic [CNT_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             col_at_end;
    logic             no_out;
    logic             past_end;
    cv3_ctl_t         ctl0;

    // control pipeline beside the data path
    logic     v1_reg, v2_reg, v3_reg, v4_reg;
    cv3_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;

    logic en;
    logic acc;
    logic wr_step;
    logic load;
    logic clearing;
    pix_t pix_in;

    pix_t [NUM_TAPS-1:0]                       window;
    logic [KERNEL_DIM-1:0][CROW_W-1:0]         crow;
    logic [NUM_TAPS-1:0][COEF_BITS-1:0]        coefs;
    logic [NUM_TAPS-1:0]                       tap_en;
    logic [NUM_CH-1:0][NUM_TAPS-1:0][CH_W-1:0] lane_taps;
    logic [NUM_CH-1:0][SUM_W-1:0]              lane_sum;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            coef_top_reg     <= RST_COEF_TOP;
            coef_middle_reg  <= RST_COEF_MIDDLE;
            coef_bottom_reg  <= RST_COEF_BOTTOM;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_HEIGHT_W-1:0];
                REG_COEF_TOP:     coef_top_reg     <= cfg_data[COEF_ROW_W-1:0];
                REG_COEF_MIDDLE:  coef_middle_reg  <= cfg_data[COEF_ROW_W-1:0];
                REG_COEF_BOTTOM:  coef_bottom_reg  <= cfg_data[COEF_ROW_W-1:0];
                default:          ;   // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // frame size, clamped to the legal range
    // ------------------------------------------------------------------
    assign w_raw = CMP_W'(image_width_reg);

    always_comb
    begin
        priority if (w_raw == '0)
        begin
            w_cl = CMP_W'(1);
        end
        else if (w_raw > CMP_W'(MAX_WIDTH))
        begin
            w_cl = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_cl = w_raw;
        end
    end

    assign w    = WID_W'(w_cl);
    assign w_m1 = w - 1'b1;

    always_comb
    begin
        priority if (image_height_reg == '0)
        begin
            h = IMG_HEIGHT_W'(1);
        end
        else if (image_height_reg > IMG_HEIGHT_W'(MAX_HEIGHT))
        begin
            h = IMG_HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            h = image_height_reg;
        end
    end

    assign h_m1 = h - 1'b1;

    // ------------------------------------------------------------------
    // position of the arriving item and which result it releases
    // ------------------------------------------------------------------
    always_comb
    begin
        // a column beyond a narrowed width restarts the row
        col_c = (WID_W'(column_count_reg) >= w) ? '0 : column_count_reg;
        row_c = row_count_reg;
        // beyond the frame plus its flush row: start over
        if ((ROW_W+1)'(row_count_reg) > (ROW_W+1)'(h) + (ROW_W+1)'(1))
        begin
            col_c = '0;
            row_c = '0;
        end

        col_at_end = (WID_W'(col_c) == w_m1);
        no_out     = (row_c == '0) || ((row_c == ROW_W'(1)) && (col_c == '0));

        // centre one pixel back, wrapping to the end of the row above
        if (col_c != '0)
        begin
            x = col_c - 1'b1;
            y = row_c - ROW_W'(1);
        end
        else
        begin
            x = CNT_W'(w_m1);
            y = row_c - ROW_W'(2);
        end

        past_end        = !no_out && (y >= ROW_W'(h));
        ctl0.emit       = !no_out && !past_end;
        ctl0.last       = ctl0.emit && (y == ROW_W'(h_m1)) && (WID_W'(x) == w_m1);
        ctl0.top_skip   = (y == '0);
        ctl0.bot_skip   = (y == ROW_W'(h_m1));
        ctl0.left_skip  = (x == '0);
        ctl0.right_skip = (WID_W'(x) == w_m1);

        if (col_at_end)
        begin
            col_next = '0;
            row_next = row_c + 1'b1;
        end
        else
        begin
            col_next = col_c + 1'b1;
            row_next = row_c;
        end
        if (past_end || ctl0.last)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // handshake and pipeline enable
    // ------------------------------------------------------------------
    // hold only when a result sits at the sum stage and the output is full
    assign en            = !(v4_reg && ctl4_reg.emit && m_axis_tvalid && !m_axis_tready);
    assign s_axis_tready = en && !clearing;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign pix_in        = (s_axis_tuser == KIND_FLUSH) ? '0 : pix_t'(s_axis_tdata);
    assign wr_step       = en && v1_reg;
    assign load          = en && v4_reg && ctl4_reg.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (acc)
        begin
            column_count_reg <= col_next;
            row_count_reg    <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else if (en)
        begin
            v1_reg   <= acc;
            ctl1_reg <= ctl0;
            v2_reg   <= v1_reg;
            ctl2_reg <= ctl1_reg;
            v3_reg   <= v2_reg;
            ctl3_reg <= ctl2_reg;
            v4_reg   <= v3_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    // ------------------------------------------------------------------
    // line stores and window
    // ------------------------------------------------------------------
    cv3_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (acc),
        .rd_addr  (col_c),
        .pix_in   (pix_in),
        .wr_step  (wr_step),
        .clearing (clearing),
        .window   (window)
    );

    // ------------------------------------------------------------------
    // kernel coefficients and border masking of the window taps
    // ------------------------------------------------------------------
    assign crow[0] = CROW_W'(coef_top_reg);
    assign crow[1] = CROW_W'(coef_middle_reg);
    assign crow[2] = CROW_W'(coef_bottom_reg);

    always_comb
    begin
        for (int k = 0; k < KERNEL_DIM; k++)
        begin
            for (int j = 0; j < KERNEL_DIM; j++)
            begin
                coefs[k*KERNEL_DIM + j]  = crow[k][j*COEF_BITS +: COEF_BITS];
                // taps outside the image read as zero
                tap_en[k*KERNEL_DIM + j] = !((k == 0 && ctl2_reg.top_skip)
                                          || (k == KERNEL_DIM - 1 && ctl2_reg.bot_skip)
                                          || (j == 0 && ctl2_reg.left_skip)
                                          || (j == KERNEL_DIM - 1 && ctl2_reg.right_skip));
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            for (int i = 0; i < NUM_TAPS; i++)
            begin
                lane_taps[c][i] = window[i][c*CH_W +: CH_W];
            end
        end
    end

    // ------------------------------------------------------------------
    // one lane per colour channel
    // ------------------------------------------------------------------
    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        cv3_lane #(
            .COEF_BITS (COEF_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (en),
            .taps   (lane_taps[ch]),
            .coefs  (coefs),
            .tap_en (tap_en),
            .sum    (lane_sum[ch])
        );
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    cv3_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .sums      (lane_sum),
        .last      (ctl4_reg.last),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // no pixel is taken while the line stores are being swept
    `CV3_ASSERT_IMP(a_no_intake_while_clearing, clk, rst_n, clearing, !s_axis_tready)
    // a waiting result is never overwritten
    `CV3_ASSERT_IMP(a_no_overwrite, clk, rst_n, (m_axis_tvalid && !m_axis_tready), !load)
    // the item releasing the frame's last result restarts the position
    `CV3_ASSERT_NXT(a_frame_restart, clk, rst_n, (acc && ctl0.last), (column_count_reg == '0 && row_count_reg == '0))
    // row position never runs past MAX_HEIGHT plus two rows
    `CV3_ASSERT_IMP(a_row_bound, clk, rst_n, 1'b1, (row_count_reg <= ROW_W'(MAX_HEIGHT + 2)))

endmodule
